[design/video_pll_clamp_setup_calc_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the video PLL and clamp setup calculator.
// Both macros expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef VIDEO_PLL_CLAMP_SETUP_CALC_MACROS_SVH
`define VIDEO_PLL_CLAMP_SETUP_CALC_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define VPCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/vpcs_pkg.sv]
// ----------------------------------------------------------------------------
// vpcs_pkg
// Types and constants of the video PLL and clamp setup calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpcs_pkg;

  localparam int unsigned DIV_STEPS = 27;
  localparam int unsigned ST_P1     = DIV_STEPS + 1;
  localparam int unsigned ST_P2     = DIV_STEPS + 2;
  localparam int unsigned ST_PCLK   = DIV_STEPS + 3;
  localparam int unsigned ST_BAND   = DIV_STEPS + 4;
  localparam int unsigned ST_OUT    = DIV_STEPS + 5;

  localparam logic [26:0] REF_CLOCK_RESET = 27'd27000000;
  localparam logic [19:0] RECIP10         = 20'd838861;
  localparam logic [31:0] RECIP1000       = 32'd2199023256;

  localparam logic [31:0] VCO_T0 = 32'd36000;
  localparam logic [31:0] VCO_T1 = 32'd70000;
  localparam logic [31:0] VCO_T2 = 32'd135000;

  localparam logic [1:0] KIND_SDTV = 2'd0;
  localparam logic [1:0] KIND_EDTV = 2'd1;
  localparam logic [1:0] KIND_HDTV = 2'd2;
  localparam logic [1:0] KIND_PC   = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [11:0]        rate;
    logic [11:0]        pix;
    logic [15:0]        lines;
    logic               want;
    logic [7:0]         sync;
    logic signed [7:0]  user;
    logic               changed;
    logic [26:0]        aq;
    logic [15:0]        arem;
    logic [26:0]        bq;
    logic [15:0]        brem;
    logic               divon;
    logic [11:0]        div12;
    logic [31:0]        prod;
    logic [7:0]         q10;
    logic [63:0]        big;
    logic [7:0]         pos;
    logic [31:0]        pclk;
    logic [1:0]         band;
    logic [2:0]         cp;
    logic [7:0]         alc;
  } vpcs_item_t;

  // Forty times the VCO gain of each band.
  function automatic logic [13:0] vco_gain40(input logic [1:0] band);
    logic [13:0] g;
    case (band)
      2'd0:    g = 14'd3000;
      2'd1:    g = 14'd3400;
      2'd2:    g = 14'd6000;
      default: g = 14'd8000;
    endcase
    return g;
  endfunction

endpackage

[design/video_pll_clamp_setup_calc.sv]
// ----------------------------------------------------------------------------
// video_pll_clamp_setup_calc
// Derives PLL, clamp and ALC settings from one video-mode description.
// ----------------------------------------------------------------------------
// Each word passes through a 33-stage pipeline and one new word can enter in
// every cycle the pipeline advances; out_valid marks it in the last stage.
// The input register is followed by 27 stages of a one-bit-per-stage restoring
// divider that forms both ref_clock_hz / refclks_line and
// 30 * samplerate / refclks_line; the last stages handle the reciprocal
// divisions, the clamp limits, the VCO band and the charge pump current.
// The whole pipeline halts while a result is held.
`timescale 1ns / 1ps
`include "video_pll_clamp_setup_calc_macros.svh"

module video_pll_clamp_setup_calc
  import vpcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [26:0]        cfg_ref_clock_hz,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_video_kind,
  input  logic [11:0]        in_samplerate,
  input  logic [11:0]        in_active_pixels,
  input  logic [15:0]        in_refclks_line,
  input  logic               in_want_post_div,
  input  logic [7:0]         in_sync_len_px,
  input  logic signed [7:0]  in_user_clamp_offset,
  input  logic               in_mode_changed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_post_div_on,
  output logic [11:0]        out_pll_divider,
  output logic [31:0]        out_pclk_khz,
  output logic [1:0]         out_vco_band,
  output logic [2:0]         out_pump_current,
  output logic [7:0]         out_clamp_start,
  output logic [5:0]         out_clamp_len,
  output logic [7:0]         out_alc_position,
  output logic               out_coast_off,
  output logic               out_sync_reset_req
);

  logic [26:0] ref_clock_hz_r;
  logic [ST_OUT:0] vld_r;
  vpcs_item_t pipe_r [0:ST_OUT];
  vpcs_item_t pipe_nxt [0:ST_OUT];
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv       = !vld_r[ST_OUT] || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_clock_hz_r <= REF_CLOCK_RESET;
    end else if (cfg_valid) begin
      ref_clock_hz_r <= cfg_ref_clock_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ST_OUT-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s <= ST_OUT; s++) begin
        pipe_r[s] <= pipe_nxt[s];
      end
    end
  end

  always_comb begin
    logic [16:0]        ta;
    logic [16:0]        tb;
    logic [16:0]        dv;
    logic               gea;
    logic               geb;
    logic [12:0]        r2;
    logic [36:0]        m10;
    logic [7:0]         ref_off;
    logic signed [10:0] p;
    logic signed [10:0] lim;
    logic               hd;
    logic [13:0]        num;
    logic [2:0]         cnt;
    vpcs_item_t         it;

    for (int s = 1; s <= ST_OUT; s++) begin
      pipe_nxt[s] = pipe_r[s-1];
    end

    it         = '0;
    it.kind    = in_video_kind;
    it.rate    = in_samplerate;
    it.pix     = (in_active_pixels == 12'd0) ? 12'd1 : in_active_pixels;
    it.lines   = (in_refclks_line == 16'd0) ? 16'd1 : in_refclks_line;
    it.want    = in_want_post_div;
    it.sync    = in_sync_len_px;
    it.user    = in_user_clamp_offset;
    it.changed = in_mode_changed;
    it.aq      = ref_clock_hz_r;
    it.bq      = {10'd0, 17'({5'd0, in_samplerate} * 17'd30)};
    pipe_nxt[0] = it;

    for (int s = 1; s <= DIV_STEPS; s++) begin
      it  = pipe_r[s-1];
      dv  = {1'b0, it.lines};
      ta  = {it.arem, it.aq[26]};
      tb  = {it.brem, it.bq[26]};
      gea = (ta >= dv);
      geb = (tb >= dv);
      it.arem = gea ? 16'(ta - dv) : ta[15:0];
      it.brem = geb ? 16'(tb - dv) : tb[15:0];
      it.aq   = {it.aq[25:0], gea};
      it.bq   = {it.bq[25:0], geb};
      pipe_nxt[s] = it;
    end

    it       = pipe_r[DIV_STEPS];
    it.divon = it.want && !it.rate[11];
    r2       = it.divon ? {it.rate, 1'b0} : {1'b0, it.rate};
    it.div12 = r2[11:0];
    it.prod  = 32'(40'(r2) * 40'(it.aq));
    m10      = 37'(17'(it.bq[16:0] + 17'd5)) * 37'(RECIP10);
    it.q10   = m10[30:23];
    pipe_nxt[ST_P1] = it;

    it      = pipe_r[ST_P1];
    hd      = (it.kind == KIND_HDTV);
    it.big  = 64'(it.prod) * 64'(RECIP1000);
    ref_off = it.sync - it.q10;
    lim     = hd ? 11'sd215 : 11'sd237;
    p       = $signed({3'b000, ref_off}) + 11'(it.user) + (hd ? 11'sd50 : 11'sd6);
    if (p < 11'sd0) begin
      it.pos = 8'd0;
    end else if (p > lim) begin
      it.pos = lim[7:0];
    end else begin
      it.pos = p[7:0];
    end
    pipe_nxt[ST_P2] = it;

    it      = pipe_r[ST_P2];
    it.pclk = {9'd0, it.big[63:41]};
    pipe_nxt[ST_PCLK] = it;

    it = pipe_r[ST_PCLK];
    if (it.pclk < VCO_T0) begin
      it.band = 2'd0;
    end else if (it.pclk < VCO_T1) begin
      it.band = 2'd1;
    end else if (it.pclk < VCO_T2) begin
      it.band = 2'd2;
    end else begin
      it.band = 2'd3;
    end
    pipe_nxt[ST_BAND] = it;

    it  = pipe_r[ST_BAND];
    hd  = (it.kind == KIND_HDTV);
    num = vco_gain40(it.band) + 14'(it.pix >> 1);
    cnt = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if ({1'b0, num} >= 15'(15'(k) * {3'd0, it.pix})) begin
        cnt = cnt + 3'd1;
      end
    end
    it.cp  = (cnt == 3'd0) ? 3'd1 : cnt;
    it.alc = it.pos + (hd ? 8'd40 : 8'd18);
    pipe_nxt[ST_OUT] = it;
  end

  assign out_valid          = vld_r[ST_OUT];
  assign out_post_div_on    = pipe_r[ST_OUT].divon;
  assign out_pll_divider    = pipe_r[ST_OUT].div12;
  assign out_pclk_khz       = pipe_r[ST_OUT].pclk;
  assign out_vco_band       = pipe_r[ST_OUT].band;
  assign out_pump_current   = pipe_r[ST_OUT].cp;
  assign out_clamp_start    = pipe_r[ST_OUT].pos;
  assign out_clamp_len      = (pipe_r[ST_OUT].kind == KIND_HDTV) ? 6'd32 : 6'd16;
  assign out_alc_position   = pipe_r[ST_OUT].alc;
  assign out_coast_off      = (pipe_r[ST_OUT].kind == KIND_PC);
  assign out_sync_reset_req = pipe_r[ST_OUT].changed;

  `VPCS_ASSERT_NOW(a_pump_range, out_valid,
    out_pump_current >= 3'd1 && out_pump_current <= 3'd6, "pump current out of range")
  `VPCS_ASSERT_NOW(a_post_div_even, out_valid && out_post_div_on,
    out_pll_divider[0] == 1'b0, "post divide with odd divider")
  `VPCS_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_r[0],
    "accepted word not in first stage")
  `VPCS_ASSERT_NOW(a_alc_place, out_valid,
    out_alc_position == 8'(out_clamp_start + 8'(out_clamp_len) +
      ((out_clamp_len == 6'd32) ? 8'd8 : 8'd2)), "ALC placement mismatch")

endmodule
